### sv/kvbd_pkg.sv
// Shared types and constants for the key/value block deframer.
package kvbd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned ROLE_W  = 3;
	localparam int unsigned REC_W   = 17;
	localparam int unsigned OUT_W   = 48;

	// Bytes of header in every entry: the key length and the value length.
	localparam logic [REC_W-1:0] HEADER_BYTES = REC_W'(4);

	typedef enum logic [ROLE_W-1:0] {
		ROLE_COUNT   = 3'd0,
		ROLE_KLEN    = 3'd1,
		ROLE_KEY     = 3'd2,
		ROLE_VLEN    = 3'd3,
		ROLE_VALUE   = 3'd4,
		ROLE_IGNORED = 3'd5
	} role_t;

endpackage

### sv/key_value_block_deframer_core.sv
// Key/value block deframer: one byte in, one classified byte out per request.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | tdata: data_byte; tuser: block_start
//  m_axis   | out       | tdata: payload_byte, entry_index, block_done, bounds_error,
//           |           | bytes_done; tuser: byte_role; tlast: record_done
//  cfg      | in        | block_length, always ready
//
// Each byte is classified in the cycle it is accepted and its result is held in the output
// register, which presents it in the next cycle; one byte per cycle is sustained while m_axis_tready is high.
// The parser state is updated by short logic on the accepted byte and the state registers.
// Reset clears the parser to the count low byte and sets block_length to 65535.
// A new request is taken whenever the output register is empty or being emptied.
module key_value_block_deframer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [kvbd_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] data_byte
	input  logic                                 s_axis_tuser,  // [0] block_start
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [7:0] payload_byte, [23:8] entry_index, [24] block_done, [25] bounds_error,
	// [41:26] bytes_done, [47:42] zero
	output logic [kvbd_pkg::OUT_W-1:0]           m_axis_tdata,
	output logic [kvbd_pkg::ROLE_W-1:0]          m_axis_tuser,  // [2:0] byte_role
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kvbd_pkg::LEN_W-1:0]           cfg_data
);
	import kvbd_pkg::*;

	typedef enum logic [3:0] {
		PH_COUNT_LO = 4'd0,
		PH_COUNT_HI = 4'd1,
		PH_KLEN_LO  = 4'd2,
		PH_KLEN_HI  = 4'd3,
		PH_KEY      = 4'd4,
		PH_VLEN_LO  = 4'd5,
		PH_VLEN_HI  = 4'd6,
		PH_VALUE    = 4'd7,
		PH_DONE     = 4'd8,
		PH_ERROR    = 4'd9
	} phase_t;

	logic [LEN_W-1:0]  block_len_q;
	phase_t            phase_q;
	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  left_q;
	logic [LEN_W-1:0]  entry_q;
	logic [BYTE_W-1:0] low_q;
	logic [LEN_W-1:0]  remain_q;
	logic [REC_W-1:0]  rec_bytes_q;
	logic [LEN_W-1:0]  done_bytes_q;

	phase_t            cur_phase, nxt_phase;
	logic [LEN_W-1:0]  cur_pos, nxt_pos;
	logic [LEN_W-1:0]  cur_left, nxt_left;
	logic [LEN_W-1:0]  cur_entry, nxt_entry;
	logic [BYTE_W-1:0] cur_low, nxt_low;
	logic [LEN_W-1:0]  cur_remain, nxt_remain;
	logic [REC_W-1:0]  cur_rec, nxt_rec;
	logic [LEN_W-1:0]  cur_done, nxt_done;

	role_t             role;
	logic              rec_end;
	logic [LEN_W-1:0]  idx;
	logic              header;
	logic [LEN_W-1:0]  len;
	logic [LEN_W+1:0]  reach;
	logic              finish;
	logic [LEN_W-1:0]  left_dec;
	logic [LEN_W-1:0]  remain_dec;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	role_t             out_role_q;
	logic [LEN_W-1:0]  out_idx_q;
	logic              out_rec_q;
	logic              out_bdone_q;
	logic              out_err_q;
	logic [LEN_W-1:0]  out_bytes_q;

	logic              in_acc;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_comb begin
		if (s_axis_tuser) begin
			cur_phase  = PH_COUNT_LO;
			cur_pos    = '0;
			cur_left   = '0;
			cur_entry  = '0;
			cur_low    = '0;
			cur_remain = '0;
			cur_rec    = '0;
			cur_done   = '0;
		end else begin
			cur_phase  = phase_q;
			cur_pos    = pos_q;
			cur_left   = left_q;
			cur_entry  = entry_q;
			cur_low    = low_q;
			cur_remain = remain_q;
			cur_rec    = rec_bytes_q;
			cur_done   = done_bytes_q;
		end
	end

	assign len        = {s_axis_tdata, cur_low};
	assign reach      = {2'b00, cur_pos} + (LEN_W+2)'(1) + {2'b00, len};
	assign remain_dec = cur_remain - LEN_W'(1);
	assign left_dec   = cur_left - LEN_W'(1);
	assign header     = (cur_phase == PH_COUNT_LO) || (cur_phase == PH_COUNT_HI) ||
	                    (cur_phase == PH_KLEN_LO) || (cur_phase == PH_KLEN_HI) ||
	                    (cur_phase == PH_VLEN_LO) || (cur_phase == PH_VLEN_HI);

	always_comb begin
		nxt_phase  = cur_phase;
		nxt_pos    = cur_pos;
		nxt_left   = cur_left;
		nxt_entry  = cur_entry;
		nxt_low    = cur_low;
		nxt_remain = cur_remain;
		nxt_rec    = cur_rec;
		nxt_done   = cur_done;
		role       = ROLE_IGNORED;
		rec_end    = 1'b0;
		idx        = cur_entry;
		finish     = 1'b0;

		if (header && (cur_pos >= block_len_q)) begin
			nxt_phase = PH_ERROR;
		end else begin
			unique case (cur_phase)
				PH_COUNT_LO: begin
					role      = ROLE_COUNT;
					idx       = '0;
					nxt_low   = s_axis_tdata;
					nxt_phase = PH_COUNT_HI;
				end
				PH_COUNT_HI: begin
					role      = ROLE_COUNT;
					idx       = '0;
					nxt_left  = len;
					nxt_phase = (len != '0) ? PH_KLEN_LO : PH_DONE;
				end
				PH_KLEN_LO, PH_VLEN_LO: begin
					role      = (cur_phase == PH_KLEN_LO) ? ROLE_KLEN : ROLE_VLEN;
					nxt_low   = s_axis_tdata;
					nxt_phase = (cur_phase == PH_KLEN_LO) ? PH_KLEN_HI : PH_VLEN_HI;
				end
				PH_KLEN_HI, PH_VLEN_HI: begin
					role = (cur_phase == PH_KLEN_HI) ? ROLE_KLEN : ROLE_VLEN;
					if (reach > {2'b00, block_len_q}) begin
						nxt_phase = PH_ERROR;
					end else begin
						nxt_remain = len;
						if (cur_phase == PH_KLEN_HI) begin
							nxt_rec   = HEADER_BYTES + {1'b0, len};
							nxt_phase = (len != '0) ? PH_KEY : PH_VLEN_LO;
						end else begin
							nxt_rec = cur_rec + {1'b0, len};
							if (len != '0) begin
								nxt_phase = PH_VALUE;
							end else begin
								rec_end = 1'b1;
								finish  = 1'b1;
							end
						end
					end
				end
				PH_KEY: begin
					role       = ROLE_KEY;
					nxt_remain = remain_dec;
					if (remain_dec == '0) begin
						nxt_phase = PH_VLEN_LO;
					end
				end
				PH_VALUE: begin
					role       = ROLE_VALUE;
					nxt_remain = remain_dec;
					if (remain_dec == '0) begin
						rec_end = 1'b1;
						finish  = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (finish) begin
				nxt_done  = cur_done + nxt_rec[LEN_W-1:0];
				nxt_entry = cur_entry + LEN_W'(1);
				nxt_left  = left_dec;
				nxt_phase = (left_dec != '0) ? PH_KLEN_LO : PH_DONE;
			end
			if (role != ROLE_IGNORED) begin
				nxt_pos = cur_pos + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q  <= '1;
			phase_q      <= PH_COUNT_LO;
			pos_q        <= '0;
			left_q       <= '0;
			entry_q      <= '0;
			low_q        <= '0;
			remain_q     <= '0;
			rec_bytes_q  <= '0;
			done_bytes_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				block_len_q <= cfg_data;
			end
			if (in_acc) begin
				phase_q      <= nxt_phase;
				pos_q        <= nxt_pos;
				left_q       <= nxt_left;
				entry_q      <= nxt_entry;
				low_q        <= nxt_low;
				remain_q     <= nxt_remain;
				rec_bytes_q  <= nxt_rec;
				done_bytes_q <= nxt_done;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_byte_q  <= s_axis_tdata;
			out_role_q  <= role;
			out_idx_q   <= idx;
			out_rec_q   <= rec_end;
			out_bdone_q <= (nxt_phase == PH_DONE);
			out_err_q   <= (nxt_phase == PH_ERROR);
			out_bytes_q <= nxt_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b000000, out_bytes_q, out_err_q, out_bdone_q, out_idx_q,
	                        out_byte_q};
	assign m_axis_tuser  = out_role_q;
	assign m_axis_tlast  = out_rec_q;

`ifndef SYNTHESIS
	a_rec_end_role: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
			(m_axis_tuser == ROLE_VALUE || m_axis_tuser == ROLE_VLEN))
		else $error("Record end on a byte that is neither value nor value length.");

	a_done_excl_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[24] && m_axis_tdata[25]))
		else $error("Block done and bounds error raised together.");

	a_done_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (left_q == '0))
		else $error("Parser done with entries still outstanding.");

	a_overrun_err: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_axis_tuser && header && (pos_q >= block_len_q)) |=>
			(m_axis_tvalid && m_axis_tdata[25] && m_axis_tuser == ROLE_IGNORED))
		else $error("Header byte past the block end did not raise the bounds error.");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for the key/value block deframer core.
module tb;
	import kvbd_pkg::*;

	typedef enum logic [3:0] {
		PH_COUNT_LO,
		PH_COUNT_HI,
		PH_KLEN_LO,
		PH_KLEN_HI,
		PH_KEY,
		PH_VLEN_LO,
		PH_VLEN_HI,
		PH_VALUE,
		PH_DONE,
		PH_ERROR
	} parse_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload;
		role_t             role;
		logic [LEN_W-1:0]  entry;
		logic              rec_done;
		logic              blk_done;
		logic              bnd_err;
		logic [LEN_W-1:0]  done_bytes;
	} byte_result_t;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_ITEMS = 1400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic [ROLE_W-1:0] m_axis_tuser;
	logic              m_axis_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data = '0;

	key_value_block_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	parse_phase_t     ph;
	logic [LEN_W-1:0] pos;
	logic [LEN_W-1:0] entries_left;
	logic [LEN_W-1:0] entry_cnt;
	logic [LEN_W-1:0] remaining;
	logic [LEN_W-1:0] blk_len;
	logic [LEN_W-1:0] done_total;
	logic [7:0]       len_lo;
	logic [REC_W-1:0] rec_bytes;

	byte_result_t pending_results[$];
	int unsigned  mismatches = 0;
	int unsigned  results_seen = 0;
	int unsigned  records_seen = 0;
	int unsigned  error_results = 0;
	int unsigned  items_sent = 0;
	int unsigned  burst_left = 0;
	bit           steady_input = 1'b0;
	int unsigned  cycle_count = 0;

	function automatic void clear_parse_state();
		ph = PH_COUNT_LO;
		pos = '0;
		entries_left = '0;
		entry_cnt = '0;
		len_lo = '0;
		remaining = '0;
		rec_bytes = '0;
		done_total = '0;
	endfunction

	function automatic void close_entry();
		done_total = done_total + rec_bytes[LEN_W-1:0];
		entry_cnt = entry_cnt + 16'd1;
		entries_left = entries_left - 16'd1;
		ph = (entries_left != 0) ? PH_KLEN_LO : PH_DONE;
	endfunction

	function automatic byte_result_t classify_byte(input logic [7:0] b, input logic start);
		byte_result_t     r;
		logic [LEN_W-1:0] len;
		logic [REC_W-1:0] reach;
		bit               header;
		if (start)
			clear_parse_state();
		r.payload = b;
		r.role = ROLE_IGNORED;
		r.entry = entry_cnt;
		r.rec_done = 1'b0;
		header = (ph != PH_KEY && ph != PH_VALUE && ph != PH_DONE && ph != PH_ERROR);
		if (header && pos >= blk_len) begin
			ph = PH_ERROR;
		end else begin
			case (ph)
				PH_COUNT_LO: begin
					r.role = ROLE_COUNT;
					r.entry = '0;
					len_lo = b;
					ph = PH_COUNT_HI;
				end
				PH_COUNT_HI: begin
					r.role = ROLE_COUNT;
					r.entry = '0;
					entries_left = {b, len_lo};
					ph = (entries_left != 0) ? PH_KLEN_LO : PH_DONE;
				end
				PH_KLEN_LO, PH_VLEN_LO: begin
					r.role = (ph == PH_KLEN_LO) ? ROLE_KLEN : ROLE_VLEN;
					len_lo = b;
					ph = (ph == PH_KLEN_LO) ? PH_KLEN_HI : PH_VLEN_HI;
				end
				PH_KLEN_HI, PH_VLEN_HI: begin
					r.role = (ph == PH_KLEN_HI) ? ROLE_KLEN : ROLE_VLEN;
					len = {b, len_lo};
					reach = {1'b0, pos} + 17'd1 + {1'b0, len};
					if (reach > {1'b0, blk_len}) begin
						ph = PH_ERROR;
					end else begin
						remaining = len;
						if (ph == PH_KLEN_HI) begin
							rec_bytes = HEADER_BYTES + {1'b0, len};
							ph = (len != 0) ? PH_KEY : PH_VLEN_LO;
						end else begin
							rec_bytes = rec_bytes + {1'b0, len};
							if (len != 0) begin
								ph = PH_VALUE;
							end else begin
								r.rec_done = 1'b1;
								close_entry();
							end
						end
					end
				end
				PH_KEY: begin
					r.role = ROLE_KEY;
					remaining = remaining - 16'd1;
					if (remaining == 0)
						ph = PH_VLEN_LO;
				end
				PH_VALUE: begin
					r.role = ROLE_VALUE;
					remaining = remaining - 16'd1;
					if (remaining == 0) begin
						r.rec_done = 1'b1;
						close_entry();
					end
				end
				default: begin
				end
			endcase
			if (r.role != ROLE_IGNORED)
				pos = pos + 16'd1;
		end
		r.blk_done = (ph == PH_DONE);
		r.bnd_err = (ph == PH_ERROR);
		r.done_bytes = done_total;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin : check_results
		byte_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result with payload 0x%0h",
					m_axis_tdata[7:0]));
			end else begin
				want = pending_results.pop_front();
				check_field("payload_byte", 16'(m_axis_tdata[7:0]), 16'(want.payload));
				check_field("entry_index", m_axis_tdata[23:8], want.entry);
				check_field("block_done", 16'(m_axis_tdata[24]), 16'(want.blk_done));
				check_field("bounds_error", 16'(m_axis_tdata[25]), 16'(want.bnd_err));
				check_field("bytes_done", m_axis_tdata[41:26], want.done_bytes);
				check_field("padding", 16'(m_axis_tdata[47:42]), '0);
				check_field("byte_role", 16'(m_axis_tuser), 16'(want.role));
				check_field("record_done", 16'(m_axis_tlast), 16'(want.rec_done));
				if (want.rec_done)
					records_seen++;
				if (want.bnd_err)
					error_results++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin : receiver_pattern
		logic [7:0]  ready_pattern;
		int unsigned stall_step;
		if (stall_step[5:0] == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = 8'hFF;
				1, 2: ready_pattern = 8'($urandom) | 8'h01;
				default: ready_pattern = 8'h01;
			endcase
		end
		m_axis_tready <= ready_pattern[stall_step[2:0]];
		stall_step++;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		int unsigned gap;
		if (!steady_input && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= start;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(classify_byte(b, start));
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_block_length(input logic [15:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		blk_len = value;
	endtask

	function automatic int unsigned pick_length();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 1)
			return $urandom_range(41, 200);
		if (sel < 11)
			return $urandom_range(7, 40);
		return $urandom_range(0, 6);
	endfunction

	task automatic test_start_without_block_start();
		// One entry with a one-byte key and an empty value, then a stray byte.
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_zero_lengths();
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_bounds_errors();
		set_block_length(16'h0000);
		send_byte(8'h5A, 1'b1);
		// The block ends exactly after the empty key, so the value length is out of bounds.
		set_block_length(16'd4);
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hC3, 1'b0);
		set_block_length(16'd6);
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	task automatic test_random_blocks();
		int unsigned      n_entries;
		int unsigned      declared;
		int unsigned      total;
		int unsigned      first_item;
		int unsigned      klens[8];
		int unsigned      vlens[8];
		logic [LEN_W-1:0] bound;
		logic [LEN_W-1:0] field;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			steady_input = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 12))
					send_byte(8'($urandom), $urandom_range(0, 5) == 0);
			end else begin
				n_entries = $urandom_range(0, 5);
				total = 2;
				for (int i = 0; i < n_entries; i++) begin
					klens[i] = pick_length();
					vlens[i] = pick_length();
					total += 4 + klens[i] + vlens[i];
				end
				case ($urandom_range(0, 5))
					0, 1: bound = 16'(total);
					2: bound = 16'(total + $urandom_range(0, 20));
					3: bound = 16'hFFFF;
					4: bound = 16'($urandom_range(0, total));
					default: bound = 16'($urandom);
				endcase
				case ($urandom_range(0, 5))
					0: declared = n_entries + $urandom_range(1, 3);
					1: declared = (n_entries > 0) ? n_entries - 1 : 0;
					2: declared = $urandom;
					default: declared = n_entries;
				endcase
				if (bound != blk_len)
					set_block_length(bound);
				field = 16'(declared);
				send_byte(field[7:0], 1'b1);
				send_byte(field[15:8], 1'b0);
				for (int i = 0; i < n_entries; i++) begin
					field = 16'(klens[i]);
					send_byte(field[7:0], 1'b0);
					send_byte(field[15:8], 1'b0);
					repeat (klens[i]) send_byte(8'($urandom), 1'b0);
					field = 16'(vlens[i]);
					send_byte(field[7:0], 1'b0);
					send_byte(field[15:8], 1'b0);
					repeat (vlens[i]) send_byte(8'($urandom), 1'b0);
				end
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
			end
		end
		steady_input = 1'b0;
		wait_idle();
	endtask

	initial begin
		blk_len = 16'hFFFF;
		clear_parse_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_start_without_block_start();
		test_zero_lengths();
		test_bounds_errors();
		test_random_blocks();
		repeat (4) @(posedge clk);
		$display("Sent %0d bytes in directed and random blocks; %0d results checked.",
			items_sent, results_seen);
		$display("%0d records completed, %0d results under a bounds error, %0d mismatches.",
			records_seen, error_results, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
